FILE: rtl/core/fixed_point_arith_unit_core_defines.svh
// ----------------------------------------------------------------------------
// fixed_point_arith_unit_core_defines.svh
// Assertion macros shared by the fixed-point arithmetic unit checkers.
// ----------------------------------------------------------------------------
`ifndef FIXED_POINT_ARITH_UNIT_CORE_DEFINES_SVH
`define FIXED_POINT_ARITH_UNIT_CORE_DEFINES_SVH

// Clocked property, masked while reset is asserted (active-low reset).
`define FPAU_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("fpau assertion failed");

// Property that applies only to a cycle in which a transaction is presented.
`define FPAU_ASSERT_WHEN(label, clk, rst_n, vld, prop) \
    `FPAU_ASSERT(label, clk, rst_n, (vld) |-> (prop))

`endif

FILE: rtl/core/fpau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpau_pkg
// Types, widths, operation codes and result packing for the fixed-point unit.
// ----------------------------------------------------------------------------
package fpau_pkg;

    localparam int unsigned DATA_W    = 32;
    localparam int unsigned FRAC_W    = 5;
    localparam int unsigned OP_W      = 3;
    localparam int unsigned DIV_STEPS = DATA_W;

    localparam logic [DATA_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

    typedef enum logic [OP_W-1:0] {
        OP_MUL   = 3'd0,
        OP_DIV   = 3'd1,
        OP_MOD   = 3'd2,
        OP_ROUND = 3'd3,
        OP_CEIL  = 3'd4,
        OP_FLOOR = 3'd5
    } t_op;

    typedef struct packed {
        logic [DATA_W-1:0] res;
        logic              sat;
        logic              dz;
    } t_res;

    // Sideband that travels with each transaction through the divider stages
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            neg;
        logic            use_div;
        t_res            r;
    } t_side;

    // Sign and magnitude to a saturated 32-bit two's complement value
    function automatic t_res pack_mag(input logic neg, input logic [63:0] mag);
        t_res r;
        r.dz  = 1'b0;
        r.sat = 1'b0;
        if (neg) begin
            if (mag > 64'h0000_0000_8000_0000) begin
                r.sat = 1'b1;
                r.res = SAT_MIN;
            end else begin
                r.res = ~mag[DATA_W-1:0] + 32'd1;
            end
        end else begin
            if (mag > 64'h0000_0000_7FFF_FFFF) begin
                r.sat = 1'b1;
                r.res = SAT_MAX;
            end else begin
                r.res = mag[DATA_W-1:0];
            end
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/fpau_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpau_in_if / fpau_out_if
// Valid/ready channels for operation requests and results.
// ----------------------------------------------------------------------------
interface fpau_in_if;
    logic                                valid;
    logic                                ready;
    logic [fpau_pkg::OP_W-1:0]           operation;
    logic signed [fpau_pkg::DATA_W-1:0]  operand_a;
    logic signed [fpau_pkg::DATA_W-1:0]  operand_b;
    logic [fpau_pkg::FRAC_W-1:0]         fraction_bits;

    modport source (output valid, operation, operand_a, operand_b, fraction_bits,
                    input ready);
    modport sink   (input valid, operation, operand_a, operand_b, fraction_bits,
                    output ready);
endinterface

interface fpau_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [fpau_pkg::DATA_W-1:0]  result;
    logic                                saturated;
    logic                                divide_by_zero;

    modport source (output valid, result, saturated, divide_by_zero, input ready);
    modport sink   (input valid, result, saturated, divide_by_zero, output ready);
endinterface

FILE: rtl/core/fixed_point_arith_unit_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_arith_unit_core
// Q-format ALU: multiply, divide, modulo, round, ceiling and floor on signed
// 32-bit operands with a per-transaction fraction width. Fully pipelined: one
// transaction is accepted per cycle unless the output stalls. The divider
// retires one quotient bit per stage over 32 stages; every operation travels
// the same path so results stay in order. Multiply and divide round half away
// from zero and saturate; a zero divisor raises divide_by_zero. A stalled
// output freezes the whole pipeline.
// ----------------------------------------------------------------------------
module fixed_point_arith_unit_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    fpau_in_if.sink      i_in,
    fpau_out_if.source   o_out
);

    localparam int unsigned W = fpau_pkg::DATA_W;
    localparam int unsigned N = fpau_pkg::DIV_STEPS;

    logic w_ce;

    // Stage 1: operand magnitudes
    logic                          r1_vld;
    logic [fpau_pkg::OP_W-1:0]     r1_op;
    logic                          r1_neg_a, r1_neg_b;
    logic [W-1:0]                  r1_ma, r1_mb, r1_a;
    logic [fpau_pkg::FRAC_W-1:0]   r1_q;

    // Stage 2: product, scaled dividend, rounding ops
    logic                          r2_vld;
    logic [63:0]                   r2_p;
    logic [fpau_pkg::FRAC_W-1:0]   r2_q;
    fpau_pkg::t_side               r2_side;
    logic [W-1:0]                  r2_hi, r2_dl, r2_mb;
    logic                          r2_ovf;

    // Divider stages
    logic                          r_dv_vld  [0:N];
    fpau_pkg::t_side               r_dv_side [0:N];
    logic [W-1:0]                  r_dv_rem  [0:N];
    logic [W-1:0]                  r_dv_dl   [0:N];
    logic [W-1:0]                  r_dv_qt   [0:N];
    logic [W-1:0]                  r_dv_mb   [0:N];
    logic                          r_dv_ovf  [0:N];

    logic                          r_out_vld;
    fpau_pkg::t_res                r_out;

    assign w_ce       = !r_out_vld || o_out.ready;
    assign i_in.ready = w_ce;

    // ---------------- stage 1 ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (w_ce) begin
            r1_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r1_op    <= i_in.operation;
            r1_neg_a <= i_in.operand_a[W-1];
            r1_neg_b <= i_in.operand_b[W-1];
            r1_ma    <= i_in.operand_a[W-1] ? (~i_in.operand_a + 32'd1) : i_in.operand_a;
            r1_mb    <= i_in.operand_b[W-1] ? (~i_in.operand_b + 32'd1) : i_in.operand_b;
            r1_a     <= i_in.operand_a;
            r1_q     <= i_in.fraction_bits;
        end
    end

    // ---------------- stage 2 ----------------
    logic [63:0]            w_p, w_n;
    logic [W:0]             w_half, w_one, w_rnd;
    logic [W-1:0]           w_frem;
    logic signed [W+1:0]    w_fl;
    logic [W+1:0]           w_fl_mag;
    fpau_pkg::t_side        n2_side;

    assign w_p    = r1_ma * r1_mb;
    assign w_n    = {32'd0, r1_ma} << ((r1_op == fpau_pkg::OP_MOD) ? 5'd0 : r1_q);
    assign w_one  = 33'd1 << r1_q;
    assign w_half = w_one >> 1;
    assign w_rnd  = (({1'b0, r1_ma} + w_half) >> r1_q) << r1_q;
    assign w_frem = r1_a & (w_one[W-1:0] - 32'd1);

    always_comb begin
        w_fl = $signed({r1_a[W-1], r1_a[W-1], r1_a}) - $signed({2'b00, w_frem});
        if (r1_op == fpau_pkg::OP_CEIL && w_frem != '0) begin
            w_fl = w_fl + $signed({1'b0, w_one});
        end
        w_fl_mag = w_fl[W+1] ? (~w_fl + 34'd1) : w_fl;
    end

    always_comb begin
        n2_side         = '0;
        n2_side.op      = r1_op;
        n2_side.neg     = (r1_op == fpau_pkg::OP_MOD) ? r1_neg_a : (r1_neg_a ^ r1_neg_b);
        n2_side.use_div = 1'b0;
        case (r1_op)
            fpau_pkg::OP_DIV: begin
                if (r1_mb == '0) begin
                    n2_side.r.dz = 1'b1;
                    if (r1_ma != '0) begin
                        n2_side.r.sat = 1'b1;
                        n2_side.r.res = r1_neg_a ? fpau_pkg::SAT_MIN : fpau_pkg::SAT_MAX;
                    end
                end else begin
                    n2_side.use_div = 1'b1;
                end
            end
            fpau_pkg::OP_MOD: begin
                if (r1_mb == '0) begin
                    n2_side.r.dz = 1'b1;
                end else begin
                    n2_side.use_div = 1'b1;
                end
            end
            fpau_pkg::OP_ROUND: n2_side.r = fpau_pkg::pack_mag(r1_neg_a, {31'd0, w_rnd});
            fpau_pkg::OP_CEIL,
            fpau_pkg::OP_FLOOR: n2_side.r = fpau_pkg::pack_mag(w_fl[W+1], {30'd0, w_fl_mag});
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (w_ce) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r2_p    <= w_p;
            r2_q    <= r1_q;
            r2_side <= n2_side;
            r2_hi   <= w_n[63:32];
            r2_dl   <= w_n[31:0];
            r2_mb   <= r1_mb;
            // quotient would need more than 32 bits: always saturates
            r2_ovf  <= (w_n[63:32] >= r1_mb);
        end
    end

    // ---------------- stage 3: multiply rounding, divider load ----------------
    logic [63:0]      w_mhalf, w_mmag;
    fpau_pkg::t_side  n3_side;

    assign w_mhalf = (64'd1 << r2_q) >> 1;
    assign w_mmag  = (r2_p + w_mhalf) >> r2_q;

    always_comb begin
        n3_side = r2_side;
        if (r2_side.op == fpau_pkg::OP_MUL) begin
            n3_side.r = fpau_pkg::pack_mag(r2_side.neg, w_mmag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_vld[0] <= 1'b0;
        end else if (w_ce) begin
            r_dv_vld[0] <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_dv_side[0] <= n3_side;
            r_dv_rem[0]  <= r2_hi;
            r_dv_dl[0]   <= r2_dl;
            r_dv_qt[0]   <= '0;
            r_dv_mb[0]   <= r2_mb;
            r_dv_ovf[0]  <= r2_ovf;
        end
    end

    // ---------------- restoring divider, one quotient bit per stage ----------------
    for (genvar k = 0; k < N; k++) begin : g_div
        logic [W:0] w_t;
        logic       w_ge;

        assign w_t  = {r_dv_rem[k], r_dv_dl[k][W-1]};
        assign w_ge = (w_t >= {1'b0, r_dv_mb[k]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[k+1] <= 1'b0;
            end else if (w_ce) begin
                r_dv_vld[k+1] <= r_dv_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_ce) begin
                r_dv_side[k+1] <= r_dv_side[k];
                r_dv_rem[k+1]  <= w_ge ? 32'(w_t - {1'b0, r_dv_mb[k]}) : w_t[W-1:0];
                r_dv_dl[k+1]   <= {r_dv_dl[k][W-2:0], 1'b0};
                r_dv_qt[k+1]   <= {r_dv_qt[k][W-2:0], w_ge};
                r_dv_mb[k+1]   <= r_dv_mb[k];
                r_dv_ovf[k+1]  <= r_dv_ovf[k];
            end
        end
    end

    // ---------------- final: quotient rounding and packing ----------------
    logic             w_up;
    logic [W:0]       w_qr;
    logic [63:0]      w_dmag;
    fpau_pkg::t_res   n_out;

    // round half away from zero: bump when twice the remainder reaches the divisor
    assign w_up   = ({r_dv_rem[N], 1'b0} >= {1'b0, r_dv_mb[N]});
    assign w_qr   = {1'b0, r_dv_qt[N]} + {32'd0, w_up};
    assign w_dmag = r_dv_ovf[N] ? 64'hFFFF_FFFF_FFFF_FFFF : {31'd0, w_qr};

    always_comb begin
        n_out = r_dv_side[N].r;
        if (r_dv_side[N].use_div) begin
            if (r_dv_side[N].op == fpau_pkg::OP_DIV) begin
                n_out = fpau_pkg::pack_mag(r_dv_side[N].neg, w_dmag);
            end else begin
                n_out = fpau_pkg::pack_mag(r_dv_side[N].neg, {32'd0, r_dv_rem[N]});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_ce) begin
            r_out_vld <= r_dv_vld[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid          = r_out_vld;
    assign o_out.result         = r_out.res;
    assign o_out.saturated      = r_out.sat;
    assign o_out.divide_by_zero = r_out.dz;

endmodule

FILE: rtl/core/fpau_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpau_checker
// Port-level checks on the fixed-point arithmetic unit, bound to the top.
// ----------------------------------------------------------------------------
`include "fixed_point_arith_unit_core_defines.svh"

module fpau_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_in_ready,
    input logic         i_out_valid,
    input logic         i_out_ready,
    input logic [31:0]  i_result,
    input logic         i_saturated,
    input logic         i_divide_by_zero
);

    // a stalled result holds
    `FPAU_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_result))
    // a clamped result sits at one of the signed limits
    `FPAU_ASSERT_WHEN(a_sat_limit, i_clk, i_rst_n, i_out_valid && i_saturated, i_result == 32'h7FFF_FFFF || i_result == 32'h8000_0000)
    // zero divisor without a clamp means a zero dividend or a modulo, so a zero result
    `FPAU_ASSERT_WHEN(a_dz_zero, i_clk, i_rst_n, i_out_valid && i_divide_by_zero && !i_saturated, i_result == 32'd0)
    // an empty output stage never blocks the request side
    `FPAU_ASSERT_WHEN(a_ready_free, i_clk, i_rst_n, !i_out_valid, i_in_ready)

endmodule

bind fixed_point_arith_unit_core fpau_checker u_fpau_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_ready       (i_in.ready),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_result         (o_out.result),
    .i_saturated      (o_out.saturated),
    .i_divide_by_zero (o_out.divide_by_zero)
);

FILE: tb/sv/fpau_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpau_result_checker
// Watches the request and result channels of the fixed-point unit, predicts
// each result from the accepted request and compares them in order.
// ----------------------------------------------------------------------------
module fpau_result_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fpau_in_if.sink     i_in,
    fpau_out_if.sink    i_out,
    output int          o_fail_count,
    output int          o_pending
);
    import fpau_pkg::*;

    t_res expected_q[$];

    function automatic t_res clamp_mag(input logic neg, input logic [63:0] mag);
        t_res r;
        r.dz  = 1'b0;
        r.sat = 1'b0;
        if (neg) begin
            if (mag > 64'h8000_0000) begin
                r.sat = 1'b1;
                r.res = SAT_MIN;
            end else begin
                r.res = 32'(64'd0 - mag);
            end
        end else if (mag > 64'h7FFF_FFFF) begin
            r.sat = 1'b1;
            r.res = SAT_MAX;
        end else begin
            r.res = mag[31:0];
        end
        return r;
    endfunction

    function automatic t_res predict_qalu(input logic [2:0] op, input logic signed [31:0] a,
                                          input logic signed [31:0] b, input logic [4:0] q);
        t_res r;
        logic [63:0] ma, mb, half, fmask, rem, qt;
        logic signed [63:0] fl;
        ma    = a < 0 ? 64'd0 - 64'(signed'(a)) : 64'(signed'(a));
        mb    = b < 0 ? 64'd0 - 64'(signed'(b)) : 64'(signed'(b));
        half  = q != 0 ? 64'd1 << (q - 1) : 64'd0;
        fmask = (64'd1 << q) - 1;
        r = '0;
        case (op)
            OP_MUL: r = clamp_mag((a < 0) != (b < 0), (ma * mb + half) >> q);
            OP_DIV: begin
                if (mb == 0) begin
                    r.dz = 1'b1;
                    if (a > 0) begin
                        r.res = SAT_MAX;
                        r.sat = 1'b1;
                    end else if (a < 0) begin
                        r.res = SAT_MIN;
                        r.sat = 1'b1;
                    end
                end else begin
                    qt = (2 * (ma << q) + mb) / (2 * mb);
                    r = clamp_mag((a < 0) != (b < 0), qt);
                end
            end
            OP_MOD: begin
                if (mb == 0) r.dz = 1'b1;
                else r = clamp_mag(a < 0, ma % mb);
            end
            OP_ROUND: r = clamp_mag(a < 0, ((ma + half) >> q) << q);
            OP_CEIL, OP_FLOOR: begin
                rem = 64'(signed'(a)) & fmask;
                fl  = 64'(signed'(a)) - signed'(rem);
                if (op == OP_CEIL && rem != 0) fl = fl + signed'(64'd1 << q);
                r = clamp_mag(fl < 0, fl < 0 ? 64'd0 - fl : fl);
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    assign o_pending = expected_q.size();

    always @(posedge i_clk) begin
        t_res exp_r;
        int   n_err;
        n_err = 0;
        if (!i_rst_n) begin
            o_fail_count <= 0;
        end else begin
            if (i_in.valid && i_in.ready)
                expected_q.push_back(predict_qalu(i_in.operation, i_in.operand_a,
                                                  i_in.operand_b, i_in.fraction_bits));
            if (i_out.valid && i_out.ready) begin
                if (expected_q.size() == 0) begin
                    $error("unexpected result transaction: result %h", i_out.result);
                    n_err = n_err + 1;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (i_out.result !== exp_r.res) begin
                        $error("result: expected %h actual %h", exp_r.res, i_out.result);
                        n_err = n_err + 1;
                    end
                    if (i_out.saturated !== exp_r.sat) begin
                        $error("saturated: expected %b actual %b", exp_r.sat, i_out.saturated);
                        n_err = n_err + 1;
                    end
                    if (i_out.divide_by_zero !== exp_r.dz) begin
                        $error("divide_by_zero: expected %b actual %b",
                               exp_r.dz, i_out.divide_by_zero);
                        n_err = n_err + 1;
                    end
                end
            end
            if (n_err != 0)
                o_fail_count <= o_fail_count + n_err;
        end
    end
endmodule

FILE: tb/sv/tb_fixed_point_arith_unit_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fixed_point_arith_unit_core
// Drives directed and random Q-format operations with random gaps and a long
// output stall; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_fixed_point_arith_unit_core;
    import fpau_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   idle_cycles;
    bit   stim_done;
    bit   long_stall_done;

    fpau_in_if  req_if ();
    fpau_out_if res_if ();

    fixed_point_arith_unit_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if.sink),
        .o_out   (res_if.source)
    );

    fpau_result_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (req_if.sink),
        .i_out        (res_if.sink),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] rand_operand();
        int p;
        logic [31:0] v;
        p = $urandom_range(0, 9);
        v = $urandom;
        case (p)
            0: return 32'h8000_0000 + $urandom_range(0, 3);
            1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            2: return 32'(signed'($urandom_range(0, 8)) - 4);
            3: return v >>> $urandom_range(8, 24);
            4: return 32'(signed'(v) >>> $urandom_range(8, 24));
            default: return v;
        endcase
    endfunction

    task automatic send_op(input logic [2:0] op, input logic [31:0] a,
                           input logic [31:0] b, input logic [4:0] q);
        int g;
        g = gap_len();
        if (g > 0) begin
            req_if.valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        req_if.valid         <= 1'b1;
        req_if.operation     <= op;
        req_if.operand_a     <= a;
        req_if.operand_b     <= b;
        req_if.fraction_bits <= q;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Receiver: random stalls plus one long hold-off so the pipeline backs up
    initial begin
        int g;
        res_if.ready    = 1'b0;
        long_stall_done = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        repeat (300) begin
            res_if.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
            g = gap_len();
            if (g > 0) begin
                res_if.ready <= 1'b0;
                repeat (g) @(negedge i_clk);
            end
        end
        res_if.ready <= 1'b0;
        repeat (150) @(negedge i_clk);
        long_stall_done = 1'b1;
        forever begin
            res_if.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(negedge i_clk);
            g = gap_len();
            if (g > 0) begin
                res_if.ready <= 1'b0;
                repeat (g) @(negedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (i_rst_n && idle_cycles >= WATCHDOG_LIMIT);
        $display("fixed_point_arith_unit_core test failed");
        $finish;
    end

    initial begin
        logic [2:0] op;
        req_if.valid         = 1'b0;
        req_if.operation     = OP_MUL;
        req_if.operand_a     = '0;
        req_if.operand_b     = '0;
        req_if.fraction_bits = '0;
        stim_done            = 1'b0;
        i_rst_n              = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: extremes, zero divisors, zero fraction bits, unknown codes
        send_op(OP_MUL,   32'h7FFF_FFFF, 32'h7FFF_FFFF, 5'd1);
        send_op(OP_MUL,   32'h8000_0000, 32'h8000_0000, 5'd31);
        send_op(OP_MUL,   32'h8000_0000, 32'h7FFF_FFFF, 5'd0);
        send_op(OP_MUL,   32'hFFFF_FFFF, 32'h0000_0001, 5'd1);
        send_op(OP_DIV,   32'h0000_0000, 32'h0000_0000, 5'd16);
        send_op(OP_DIV,   32'h0000_0005, 32'h0000_0000, 5'd16);
        send_op(OP_DIV,   32'hFFFF_FFFB, 32'h0000_0000, 5'd16);
        send_op(OP_DIV,   32'h8000_0000, 32'hFFFF_FFFF, 5'd0);
        send_op(OP_DIV,   32'h0000_0001, 32'h0000_0003, 5'd31);
        send_op(OP_DIV,   32'h7FFF_FFFF, 32'h8000_0000, 5'd31);
        send_op(OP_MOD,   32'h0000_0007, 32'h0000_0000, 5'd8);
        send_op(OP_MOD,   32'hFFFF_FFF9, 32'h0000_0003, 5'd8);
        send_op(OP_MOD,   32'h8000_0000, 32'hFFFF_FFFF, 5'd8);
        send_op(OP_ROUND, 32'h7FFF_FFFF, 32'h0,         5'd31);
        send_op(OP_ROUND, 32'h8000_0000, 32'h0,         5'd31);
        send_op(OP_ROUND, 32'hFFFF_FF80, 32'h0,         5'd8);
        send_op(OP_ROUND, 32'h1234_5678, 32'h0,         5'd0);
        send_op(OP_CEIL,  32'h7FFF_FFFF, 32'h0,         5'd4);
        send_op(OP_CEIL,  32'h8000_0001, 32'h0,         5'd31);
        send_op(OP_CEIL,  32'h1234_5678, 32'h0,         5'd0);
        send_op(OP_FLOOR, 32'h8000_0000, 32'h0,         5'd31);
        send_op(OP_FLOOR, 32'hFFFF_FFFF, 32'h0,         5'd1);
        send_op(3'd6,     32'h1234_5678, 32'h1,         5'd3);
        send_op(3'd7,     32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31);

        repeat (800) begin
            op = $urandom_range(0, 99) < 97 ? 3'($urandom_range(0, 5))
                                             : 3'($urandom_range(6, 7));
            send_op(op, rand_operand(),
                    $urandom_range(0, 19) == 0 ? 32'd0 : rand_operand(),
                    5'($urandom_range(0, 31)));
        end
        req_if.valid <= 1'b0;
        stim_done = 1'b1;
    end

    initial begin
        wait (stim_done && long_stall_done && pending == 0);
        repeat (60) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("fixed_point_arith_unit_core test passed");
        else
            $display("fixed_point_arith_unit_core test failed");
        $finish;
    end
endmodule
